@@ hw/rtl/nfsa_pkg.sv @@
package nfsa_pkg;

    localparam int SLOTS_DEF = 4096;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_RECOUNT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_WAS_FREE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [11:0] slot_in;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [11:0] slot_out;
        logic [12:0] free_count_out;
    } t_out;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_WIPE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic chk;
        logic wipe;
        logic out_load;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic skip;
        logic chk_done;
        logic wipe_last;
        logic out_free;
    } t_sts;

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [5:0] popcnt32(input logic [31:0] v);
        return 6'(popcnt8(v[7:0])) + 6'(popcnt8(v[15:8]))
             + 6'(popcnt8(v[23:16])) + 6'(popcnt8(v[31:24]));
    endfunction

endpackage

@@ hw/rtl/nfsa_ctrl.sv @@
module nfsa_ctrl import nfsa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_cmd   i_cmd,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_ctl   o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_sts.wipe_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd) inside
                        CMD_ALLOC, CMD_RELEASE: n_state = i_sts.skip ? S_DONE : S_RD;
                        CMD_CLEAR:              n_state = S_WIPE;
                        CMD_RECOUNT:            n_state = S_RD;
                        default:                n_state = S_RD;
                    endcase
                end
            end
            S_RD:   n_state = S_CHK;
            S_CHK:  n_state = i_sts.chk_done ? S_DONE : S_RD;
            S_WIPE: begin
                if (i_sts.wipe_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: o_ctl.wipe = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            S_RD:   o_ctl.rd = 1'b1;
            S_CHK:  o_ctl.chk = 1'b1;
            S_WIPE: o_ctl.wipe = 1'b1;
            S_DONE: o_ctl.out_load = i_sts.out_free;
            default: o_ctl = '0;
        endcase
    end

    // every word check works on data fetched the cycle before
    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> $past(r_state) == S_RD)
        else $error("word check without a read");

    a_rd_then_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_CHK)
        else $error("read not followed by a word check");

    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) != S_DONE) |->
        ($past(r_state) == S_IDLE || $past(r_state) == S_CHK || $past(r_state) == S_WIPE))
        else $error("unexpected entry into result state");

endmodule

@@ hw/rtl/nfsa_dp.sv @@
module nfsa_dp import nfsa_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_in    i_in,
    input  t_ctl   i_ctl,
    input  logic   i_out_ready,
    output t_sts   o_sts,
    output logic   o_out_valid,
    output t_out   o_out
);

    localparam int NW        = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (NW > 1) ? $clog2(NW) : 1;
    localparam int KW        = $clog2(NW + 1);
    localparam int CW        = $clog2(SLOTS + 1);
    localparam int LAST_BITS = SLOTS - (NW - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

    // bitmap, one flag per slot, WORD_BITS slots per word
    logic [WORD_BITS-1:0] mem [NW];

    logic [WW-1:0]        r_addr,       n_addr;
    logic [KW-1:0]        r_k,          n_k;
    logic [WW-1:0]        r_ptr_word,   n_ptr_word;
    logic [BIT_W-1:0]     r_ptr_bit,    n_ptr_bit;
    logic [CW-1:0]        r_free_count, n_free_count;
    logic                 r_out_valid,  n_out_valid;
    t_cmd                 r_cmd,        n_cmd;
    logic [BIT_W-1:0]     r_bit,        n_bit;
    t_status              r_status,     n_status;
    t_out                 r_out,        n_out;
    logic [WORD_BITS-1:0] r_rdata;

    logic                 in_range;
    logic                 last_word;
    logic                 k_end;
    logic [WW-1:0]        addr_next;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] cand;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;
    logic [5:0]           zeros;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    assign in_range   = 32'(i_in.slot_in) < 32'(SLOTS);
    assign last_word  = r_addr == WW'(NW - 1);
    assign k_end      = r_k == KW'(NW);
    assign addr_next  = last_word ? '0 : r_addr + WW'(1);
    assign valid_mask = last_word ? LAST_MASK : '1;
    assign lo_mask    = {WORD_BITS{1'b1}} << r_bit;

    // first lap starts at the pointer bit; the final visit of the start
    // word covers only the bits below it
    always_comb begin
        if (r_k == '0) begin
            scan_mask = lo_mask;
        end else if (k_end) begin
            scan_mask = ~lo_mask;
        end else begin
            scan_mask = '1;
        end
    end

    assign cand  = ~r_rdata & scan_mask & valid_mask;
    assign found = |cand;
    assign zeros = popcnt32(~r_rdata & valid_mask);

    always_comb begin
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) found_bit = BIT_W'(i);
        end
    end

    always_comb begin
        o_sts.skip      = (i_in.command == CMD_ALLOC && r_free_count == '0)
                       || (i_in.command == CMD_RELEASE && !in_range);
        o_sts.wipe_last = last_word;
        o_sts.out_free  = !r_out_valid || i_out_ready;
        case (r_cmd)
            CMD_ALLOC:   o_sts.chk_done = found || k_end;
            CMD_RECOUNT: o_sts.chk_done = last_word;
            default:     o_sts.chk_done = 1'b1;
        endcase
    end

    always_comb begin
        n_addr       = r_addr;
        n_k          = r_k;
        n_ptr_word   = r_ptr_word;
        n_ptr_bit    = r_ptr_bit;
        n_free_count = r_free_count;
        n_cmd        = r_cmd;
        n_bit        = r_bit;
        n_status     = r_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        mem_we       = 1'b0;
        mem_wdata    = '0;

        if (i_ctl.load) begin
            n_cmd    = i_in.command;
            n_k      = '0;
            n_status = (i_in.command == CMD_ALLOC && r_free_count == '0) ? ST_FULL : ST_OK;
            case (i_in.command)
                CMD_ALLOC: begin
                    n_addr = r_ptr_word;
                    n_bit  = r_ptr_bit;
                end
                CMD_RELEASE: begin
                    n_addr = WW'(i_in.slot_in >> BIT_W);
                    n_bit  = i_in.slot_in[BIT_W-1:0];
                end
                CMD_CLEAR: begin
                    n_addr       = '0;
                    n_ptr_word   = '0;
                    n_ptr_bit    = '0;
                    n_free_count = CW'(SLOTS);
                end
                default: begin
                    n_addr       = '0;
                    n_free_count = '0;
                end
            endcase
        end

        if (i_ctl.wipe) begin
            mem_we = 1'b1;
            n_addr = addr_next;
        end

        if (i_ctl.chk) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (found) begin
                        mem_we       = 1'b1;
                        mem_wdata    = r_rdata | (WORD_BITS'(1) << found_bit);
                        n_ptr_word   = r_addr;
                        n_ptr_bit    = found_bit;
                        n_free_count = r_free_count - CW'(1);
                    end else if (k_end) begin
                        n_status = ST_FULL;
                    end else begin
                        n_k    = r_k + KW'(1);
                        n_addr = addr_next;
                    end
                end
                CMD_RELEASE: begin
                    if (r_rdata[r_bit]) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata & ~(WORD_BITS'(1) << r_bit);
                        if (r_free_count < CW'(SLOTS)) begin
                            n_free_count = r_free_count + CW'(1);
                        end
                    end else begin
                        n_status = ST_WAS_FREE;
                    end
                end
                CMD_RECOUNT: begin
                    n_free_count = r_free_count + CW'(zeros);
                    n_addr       = addr_next;
                end
                default: n_status = ST_OK;
            endcase
        end

        if (i_ctl.out_load) begin
            n_out_valid          = 1'b1;
            n_out.status         = r_status;
            n_out.slot_out       = 12'({r_ptr_word, r_ptr_bit});
            n_out.free_count_out = 13'(r_free_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_k          <= '0;
            r_ptr_word   <= '0;
            r_ptr_bit    <= '0;
            r_free_count <= CW'(SLOTS);
            r_out_valid  <= 1'b0;
        end else begin
            r_addr       <= n_addr;
            r_k          <= n_k;
            r_ptr_word   <= n_ptr_word;
            r_ptr_bit    <= n_ptr_bit;
            r_free_count <= n_free_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CW'(SLOTS))
        else $error("free count above slot total");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'({r_ptr_word, r_ptr_bit}) < 32'(SLOTS))
        else $error("search pointer out of range");

    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.chk && r_cmd == CMD_ALLOC && found) |=>
        r_free_count == $past(r_free_count) - CW'(1))
        else $error("grant did not take one from the free count");

endmodule

@@ hw/rtl/next_fit_slot_allocator.sv @@
// Channel | Dir | Handshake                 | Beat
// in      | in  | i_in_valid / o_in_ready   | i_in   (command, slot_in)
// out     | out | o_out_valid / i_out_ready | o_out  (status, slot_out, free_count_out)
//
// One item at a time. Allocate reads and checks bitmap words in turn (32 slots per
// word, up to SLOTS/32 + 1 words), release one word; a full allocate or an
// out-of-range release skips the memory; recount reads every word, clear writes
// every word, all through the single-port bitmap memory (one word read or written
// per cycle). After reset a clearing pass over the bitmap runs before the first
// beat is taken. The output register lets the next beat in while a result waits;
// a stalled output only holds the block once it has the following result ready.
module next_fit_slot_allocator import nfsa_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_ctl ctl;
    t_sts sts;

    nfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in.command),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl)
    );

    nfsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ tb/tb_next_fit_slot_allocator.sv @@
`timescale 1ns / 100ps

module tb_next_fit_slot_allocator;
    import nfsa_pkg::*;

    localparam int SLOTS            = SLOTS_DEF;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int SETTLE_CYCLES    = 300;
    localparam int MAX_CYCLES       = 6_000_000;

    // Allocator state as the block should hold it
    typedef struct packed {
        bit [SLOTS-1:0] used;
        bit [11:0]      ptr;
        bit [12:0]      count;
    } t_slot_map;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic out_ready   = 1'b0;
    t_in  in_data     = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    t_slot_map   dut_map;
    t_slot_map   plan_map;
    t_in         pending_cmds[$];
    t_out        expected_results[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    next_fit_slot_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_slot_map fresh_map();
        t_slot_map m;
        m.used  = '0;
        m.ptr   = '0;
        m.count = 13'(SLOTS);
        return m;
    endfunction

    // Applies one command to a map and returns the beat it should produce
    function automatic t_out next_fit_step(inout t_slot_map m, input t_in beat);
        t_out        r;
        int unsigned p;
        int unsigned steps;
        int unsigned nfree;
        r.status = ST_OK;
        if (m.ptr >= SLOTS) begin
            m.ptr = '0;
        end
        case (beat.command)
            CMD_ALLOC: begin
                if (m.count == 0) begin
                    r.status = ST_FULL;
                end else begin
                    p = m.ptr;
                    steps = 0;
                    while (steps < SLOTS && m.used[p]) begin
                        p = (p + 1 == SLOTS) ? 0 : p + 1;
                        steps++;
                    end
                    m.ptr = p[11:0];
                    if (!m.used[p]) begin
                        m.used[p] = 1'b1;
                        m.count   = m.count - 1'b1;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            CMD_RELEASE: begin
                if (beat.slot_in < SLOTS) begin
                    if (!m.used[beat.slot_in]) begin
                        r.status = ST_WAS_FREE;
                    end else begin
                        m.used[beat.slot_in] = 1'b0;
                        if (m.count < SLOTS) begin
                            m.count = m.count + 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                m = fresh_map();
            end
            default: begin
                nfree = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!m.used[i]) begin
                        nfree++;
                    end
                end
                m.count = nfree[12:0];
            end
        endcase
        r.slot_out       = m.ptr;
        r.free_count_out = m.count;
        return r;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Queues a command; the planning map tracks which slots will be in use
    task automatic push_cmd(input t_cmd c, input logic [11:0] s);
        t_in  beat;
        t_out ignored;
        beat.command = c;
        beat.slot_in = s;
        ignored = next_fit_step(plan_map, beat);
        pending_cmds.push_back(beat);
    endtask

    task automatic push_random_cmd();
        int unsigned sel;
        int unsigned start;
        int unsigned k;
        logic [11:0] slot;
        sel  = $urandom_range(0, 99);
        slot = 12'($urandom);
        if (sel < 45) begin
            push_cmd(CMD_ALLOC, slot);
        end else if (sel < 85) begin
            // mostly release a slot that is held, else any slot
            if ($urandom_range(0, 3) != 0 && plan_map.count < SLOTS) begin
                start = $urandom_range(0, SLOTS - 1);
                k = 0;
                while (k < SLOTS && !plan_map.used[(start + k) % SLOTS]) begin
                    k++;
                end
                slot = 12'((start + k) % SLOTS);
            end
            push_cmd(CMD_RELEASE, slot);
        end else if (sel < 87) begin
            push_cmd(CMD_CLEAR, slot);
        end else begin
            push_cmd(CMD_RECOUNT, slot);
        end
    endtask

    // Driver: when a beat is accepted, the model's expected result for it is queued
    always @(posedge i_clk) begin : drive
        logic next_valid;
        t_in  next_data;
        t_out want;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            next_data  = in_data;
            if (in_valid && o_in_ready) begin
                want = next_fit_step(dut_map, in_data);
                expected_results.push_back(want);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_cmds.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                next_data  = pending_cmds.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
            in_data  <= next_data;
        end
    end

    always @(posedge i_clk) begin : observe
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    log_failure($sformatf("unexpected beat: status %0d slot %0d free %0d",
                        o_out.status, o_out.slot_out, o_out.free_count_out));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.status !== want.status || o_out.slot_out !== want.slot_out
                        || o_out.free_count_out !== want.free_count_out) begin
                        log_failure($sformatf(
                            "mismatch: exp status %0d slot %0d free %0d, got %0d %0d %0d",
                            want.status, want.slot_out, want.free_count_out,
                            o_out.status, o_out.slot_out, o_out.free_count_out));
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** next_fit_slot_allocator: FAILED **");
        $finish;
    end

    initial begin : stimulus
        dut_map  = fresh_map();
        plan_map = fresh_map();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 0) begin
                push_cmd(CMD_ALLOC,   12'h000);
                push_cmd(CMD_ALLOC,   12'hFFF);
                push_cmd(CMD_ALLOC,   12'h123);
                push_cmd(CMD_RELEASE, 12'h001);
                push_cmd(CMD_RELEASE, 12'h001);   // already free
                push_cmd(CMD_RELEASE, 12'hFFF);   // top slot, never taken
                push_cmd(CMD_RELEASE, 12'h000);
                push_cmd(CMD_ALLOC,   12'hAAA);   // pointer sits on a used slot
                push_cmd(CMD_RECOUNT, 12'h555);
                push_cmd(CMD_RELEASE, 12'hAAA);
                push_cmd(CMD_RELEASE, 12'h555);
                push_cmd(CMD_CLEAR,   12'hFFF);
                push_cmd(CMD_ALLOC,   12'hFFF);
                push_cmd(CMD_RECOUNT, 12'h000);
            end
            repeat (RANDOM_PER_PHASE) push_random_cmd();
            // hold the sender until every result of this phase is back
            do @(negedge i_clk);
            while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (fail_count == 0) begin
            $display("** next_fit_slot_allocator: PASSED **");
        end else begin
            $display("** next_fit_slot_allocator: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_ctrl.sv
hw/rtl/nfsa_dp.sv
hw/rtl/next_fit_slot_allocator.sv
tb/tb_next_fit_slot_allocator.sv
